[rtl/mcrrs_pkg.sv]
// Shared types and constants for the multicore round-robin/FCFS scheduler.
`default_nettype none
package mcrrs_pkg;

    localparam int CORES_DEF  = 4;
    localparam int QDEPTH_DEF = 16;

    localparam int JOB_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;
    localparam int AC_W   = 3;
    localparam int TCNT_W = 32;

    localparam logic [CFG_W-1:0] DELAY_RST = 16'd1;
    localparam logic [CFG_W-1:0] QUANT_RST = 16'd5;
    localparam logic [AC_W-1:0]  ACT_RST   = 3'd4;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_DELAY   = 2'd1,
        REG_QUANTUM = 2'd2,
        REG_ACTIVE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        EV_ENQ  = 3'd0,
        EV_FULL = 3'd1,
        EV_DISP = 3'd2,
        EV_PRE  = 3'd3,
        EV_FIN  = 3'd4,
        EV_SUM  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_SCHED,
        S_RD,
        S_DISP,
        S_REDISP,
        S_COUNT,
        S_EXEC,
        S_SUM
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  enq;
        logic  c_clear;
        logic  c_inc;
        logic  preempt;
        logic  dispatch;
        logic  push_held;
        logic  disp_mem;
        logic  count_upd;
        logic  exec_step;
        logic  emit;
        logic  last;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic q_empty;
        logic q_full;
        logic mode;
        logic c_done;
        logic cur_busy;
        logic cur_qzero;
        logic cur_fin;
        logic can_emit;
    } status_t;

endpackage
`default_nettype wire

[rtl/mcrrs_ctrl.sv]
// Scheduler sequencer: walks enqueue and tick transactions through their phases.
`default_nettype none
module mcrrs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mcrrs_pkg::status_t st,
    output mcrrs_pkg::cmd_t      cmd
);
    import mcrrs_pkg::*;

    state_t state_reg, state_next;
    logic   pre_reg, pre_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pre_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pre_next   = pre_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.kind   = EV_SUM;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.c_clear = 1'b1;
                    state_next  = st.op ? S_SCHED : S_ENQ;
                end
            end
            S_ENQ:
            begin
                if (st.can_emit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = st.q_full ? EV_FULL : EV_ENQ;
                    cmd.enq    = !st.q_full;
                    state_next = S_IDLE;
                end
            end
            S_SCHED:
            begin
                pre_next = 1'b0;
                if (st.c_done)
                    state_next = S_COUNT;
                else if (!st.mode)
                begin
                    if (st.q_empty)
                        state_next = S_COUNT;
                    else if (!st.cur_busy)
                        state_next = S_RD;
                    else
                        cmd.c_inc = 1'b1;
                end
                else if (!st.cur_busy)
                begin
                    if (!st.q_empty)
                        state_next = S_RD;
                    else
                        cmd.c_inc = 1'b1;
                end
                else if (st.cur_qzero)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.kind    = EV_PRE;
                        cmd.preempt = 1'b1;
                        pre_next    = 1'b1;
                        state_next  = st.q_empty ? S_REDISP : S_RD;
                    end
                end
                else
                    cmd.c_inc = 1'b1;
            end
            S_RD:
                state_next = S_DISP;
            S_DISP:
            begin
                if (st.can_emit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = EV_DISP;
                    cmd.disp_mem  = 1'b1;
                    cmd.dispatch  = 1'b1;
                    cmd.push_held = pre_reg;
                    cmd.c_inc     = 1'b1;
                    state_next    = S_SCHED;
                end
            end
            S_REDISP:
            begin
                if (st.can_emit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EV_DISP;
                    cmd.c_inc  = 1'b1;
                    state_next = S_SCHED;
                end
            end
            S_COUNT:
            begin
                cmd.count_upd = 1'b1;
                cmd.c_clear   = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (st.c_done)
                    state_next = S_SUM;
                else if (st.cur_fin)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.kind      = EV_FIN;
                        cmd.exec_step = 1'b1;
                        cmd.c_inc     = 1'b1;
                    end
                end
                else
                begin
                    cmd.exec_step = 1'b1;
                    cmd.c_inc     = 1'b1;
                end
            end
            S_SUM:
            begin
                if (st.can_emit)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = EV_SUM;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/mcrrs_dp.sv]
// Scheduler datapath: config registers, ready queue memory, core state, counters, output.
`default_nettype none
module mcrrs_dp #(
    parameter int CORES       = mcrrs_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = mcrrs_pkg::QDEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [mcrrs_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                           operation,
    input  wire logic [mcrrs_pkg::JOB_W-1:0]    job_id,
    input  wire logic [mcrrs_pkg::JOB_W-1:0]    instr_count,
    input  wire mcrrs_pkg::cmd_t                cmd,
    output mcrrs_pkg::status_t                  st,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          event_kind,
    output logic [mcrrs_pkg::CIDX_W-1:0]        core_index,
    output logic [mcrrs_pkg::JOB_W-1:0]         event_job,
    output logic                                tick_idle,
    output logic [mcrrs_pkg::TCNT_W-1:0]        idle_ticks,
    output logic [mcrrs_pkg::TCNT_W-1:0]        active_ticks,
    output logic                                last_event
);
    import mcrrs_pkg::*;

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = $clog2(CORES + 1);
    localparam int IW  = (CORES > 1) ? $clog2(CORES) : 1;

    logic             mode_reg;
    logic [CFG_W-1:0] delay_rl_reg, quant_len_reg;
    logic [AC_W-1:0]  act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            delay_rl_reg  <= DELAY_RST;
            quant_len_reg <= QUANT_RST;
            act_reg       <= ACT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MODE:    mode_reg      <= cfg_data[0];
                REG_DELAY:   delay_rl_reg  <= cfg_data;
                REG_QUANTUM: quant_len_reg <= cfg_data;
                REG_ACTIVE:  act_reg       <= cfg_data[AC_W-1:0];
                default:     mode_reg      <= mode_reg;
            endcase
        end
    end

    logic [CW-1:0] n_act;
    always_comb
    begin
        if (act_reg == '0)
            n_act = CW'(1);
        else if (int'(act_reg) > CORES)
            n_act = CW'(CORES);
        else
            n_act = CW'(act_reg);
    end

    // captured transaction
    logic [JOB_W-1:0] in_job_reg, in_cnt_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_job_reg <= job_id;
            in_cnt_reg <= instr_count;
        end
    end

    // core walk counter
    logic [CW-1:0] c_reg;
    logic [IW-1:0] c_idx;
    assign c_idx = c_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg <= '0;
        else if (cmd.c_clear)
            c_reg <= '0;
        else if (cmd.c_inc)
            c_reg <= c_reg + CW'(1);
    end

    // ready queue
    logic [2*JOB_W-1:0] qmem [QUEUE_DEPTH];
    logic [2*JOB_W-1:0] q_rd_reg;
    logic [AW-1:0]      head_reg;
    logic [QCW-1:0]     count_reg;
    logic [AW-1:0]      tail, head_inc;
    logic [QCW:0]       tail_sum;
    logic [JOB_W-1:0]   hold_job_reg, hold_rem_reg;

    assign tail_sum = (QCW+1)'(head_reg) + (QCW+1)'(count_reg);
    assign tail     = (tail_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (QCW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.enq)
            qmem[tail] <= {in_job_reg, in_cnt_reg};
        else if (cmd.dispatch && cmd.push_held)
            qmem[tail] <= {hold_job_reg, hold_rem_reg};
        q_rd_reg <= qmem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.enq)
            count_reg <= count_reg + QCW'(1);
        else if (cmd.dispatch)
        begin
            head_reg <= head_inc;
            if (!cmd.push_held)
                count_reg <= count_reg - QCW'(1);
        end
    end

    // core state
    logic [CORES-1:0] busy_reg;
    logic [JOB_W-1:0] core_job_reg   [CORES];
    logic [JOB_W-1:0] core_rem_reg   [CORES];
    logic [CFG_W-1:0] core_delay_reg [CORES];
    logic [CFG_W-1:0] core_quant_reg [CORES];

    logic             cur_busy, cur_dz;
    logic [JOB_W-1:0] cur_rem;
    assign cur_busy = busy_reg[c_idx];
    assign cur_dz   = (core_delay_reg[c_idx] == '0);
    assign cur_rem  = core_rem_reg[c_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.preempt)
        begin
            hold_job_reg <= core_job_reg[c_idx];
            hold_rem_reg <= core_rem_reg[c_idx];
        end
        if (cmd.dispatch)
        begin
            core_job_reg[c_idx] <= q_rd_reg[2*JOB_W-1:JOB_W];
            core_rem_reg[c_idx] <= q_rd_reg[JOB_W-1:0];
        end
        else if (cmd.exec_step && cur_busy && cur_dz)
            core_rem_reg[c_idx] <= cur_rem - JOB_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int i = 0; i < CORES; i++)
            begin
                core_delay_reg[i] <= DELAY_RST;
                core_quant_reg[i] <= QUANT_RST;
            end
        end
        else
        begin
            if (cmd.preempt)
                core_quant_reg[c_idx] <= quant_len_reg;
            if (cmd.dispatch)
                busy_reg[c_idx] <= 1'b1;
            if (cmd.exec_step && cur_busy)
            begin
                if (cur_dz)
                begin
                    core_delay_reg[c_idx] <= delay_rl_reg;
                    if (cur_rem == JOB_W'(1))
                    begin
                        busy_reg[c_idx]       <= 1'b0;
                        core_quant_reg[c_idx] <= quant_len_reg;
                    end
                    else if (core_quant_reg[c_idx] != '0)
                        core_quant_reg[c_idx] <= core_quant_reg[c_idx] - CFG_W'(1);
                end
                else
                    core_delay_reg[c_idx] <= core_delay_reg[c_idx] - CFG_W'(1);
            end
        end
    end

    // tick statistics
    logic              any_busy;
    logic              tidle_reg;
    logic [TCNT_W-1:0] idle_cnt_reg, act_cnt_reg;

    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < CORES; i++)
            if (busy_reg[i] && (i < int'(n_act)))
                any_busy = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cnt_reg <= '0;
            act_cnt_reg  <= '0;
            tidle_reg    <= 1'b0;
        end
        else if (cmd.count_upd)
        begin
            tidle_reg <= !any_busy;
            if (any_busy)
                act_cnt_reg <= act_cnt_reg + TCNT_W'(1);
            else
                idle_cnt_reg <= idle_cnt_reg + TCNT_W'(1);
        end
    end

    // result register
    logic              out_valid_reg;
    logic [2:0]        kind_reg;
    logic [CIDX_W-1:0] cidx_reg;
    logic [JOB_W-1:0]  ejob_reg;
    logic              tidle_out_reg, last_reg;
    logic [TCNT_W-1:0] icnt_out_reg, acnt_out_reg;
    logic              can_emit;
    logic [JOB_W-1:0]  job_sel;

    assign can_emit = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.kind)
            EV_ENQ, EV_FULL: job_sel = in_job_reg;
            EV_DISP:         job_sel = cmd.disp_mem ? q_rd_reg[2*JOB_W-1:JOB_W]
                                                    : core_job_reg[c_idx];
            EV_PRE, EV_FIN:  job_sel = core_job_reg[c_idx];
            default:         job_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg      <= cmd.kind;
            cidx_reg      <= (cmd.kind == EV_DISP || cmd.kind == EV_PRE ||
                              cmd.kind == EV_FIN) ? CIDX_W'(c_reg) : '0;
            ejob_reg      <= job_sel;
            tidle_out_reg <= (cmd.kind == EV_SUM) ? tidle_reg : 1'b0;
            icnt_out_reg  <= (cmd.kind == EV_SUM) ? idle_cnt_reg : '0;
            acnt_out_reg  <= (cmd.kind == EV_SUM) ? act_cnt_reg : '0;
            last_reg      <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign core_index   = cidx_reg;
    assign event_job    = ejob_reg;
    assign tick_idle    = tidle_out_reg;
    assign idle_ticks   = icnt_out_reg;
    assign active_ticks = acnt_out_reg;
    assign last_event   = last_reg;

    always_comb
    begin
        st           = '0;
        st.op        = operation;
        st.q_empty   = (count_reg == '0);
        st.q_full    = (count_reg >= QCW'(QUEUE_DEPTH));
        st.mode      = mode_reg;
        st.c_done    = (c_reg == n_act);
        st.cur_busy  = cur_busy;
        st.cur_qzero = (core_quant_reg[c_idx] == '0);
        st.cur_fin   = cur_busy && cur_dz && (cur_rem == JOB_W'(1));
        st.can_emit  = can_emit;
    end

endmodule
`default_nettype wire

[rtl/multicore_rr_fcfs_scheduler_unit.sv]
// Multicore job scheduler (FCFS / round robin) top level.
// Input channel (in_valid/in_ready): operation 0 enqueues job_id with
// instr_count, operation 1 advances one scheduling tick. One transaction is
// worked on at a time; in_ready is high only while the sequencer is idle.
// Output channel (out_valid/out_ready): one result per event, last_event
// marks the final result of a transaction (enqueue/full reply or tick summary).
// Enqueue: accept, then post the result. Tick: accept, then a scheduling walk
// over the active cores; each dispatch from the queue adds a registered queue
// read and a dispatch step, each preempt that re-dispatches the same job adds
// a re-dispatch step; then a step to close the walk, the idle/active count, an
// execution walk over the active cores, and the summary.
// The result sits in an output register; the sequencer stalls only when it
// must post a new result while the previous one has not been taken.
// Config port: cfg_wr_en/cfg_index/cfg_data, to be written by the user only
// while idle; the block itself does not enforce this.
// Reset: asynchronous, active low; queue empty, cores free, counters zero,
// registers at their defaults.
`default_nettype none
module multicore_rr_fcfs_scheduler_unit #(
    parameter int CORES       = mcrrs_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = mcrrs_pkg::QDEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [mcrrs_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [mcrrs_pkg::JOB_W-1:0]  job_id,
    input  wire logic [mcrrs_pkg::JOB_W-1:0]  instr_count,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [2:0]                        event_kind,
    output logic [mcrrs_pkg::CIDX_W-1:0]      core_index,
    output logic [mcrrs_pkg::JOB_W-1:0]       event_job,
    output logic                              tick_idle,
    output logic [mcrrs_pkg::TCNT_W-1:0]      idle_ticks,
    output logic [mcrrs_pkg::TCNT_W-1:0]      active_ticks,
    output logic                              last_event
);
    import mcrrs_pkg::*;

    cmd_t    cmd;
    status_t st;

    mcrrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mcrrs_dp #(
        .CORES       (CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .job_id       (job_id),
        .instr_count  (instr_count),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .core_index   (core_index),
        .event_job    (event_job),
        .tick_idle    (tick_idle),
        .idle_ticks   (idle_ticks),
        .active_ticks (active_ticks),
        .last_event   (last_event)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in progress");

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.q_empty && st.q_full))
        else $error("queue both empty and full");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_event) |-> (event_kind == EV_SUM ||
            event_kind == EV_ENQ || event_kind == EV_FULL))
        else $error("final result of a transaction has wrong kind");

    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.can_emit)
        else $error("result posted over an untaken result");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_multicore_rr_fcfs_scheduler_unit.sv]
// Self-checking testbench for the multicore FCFS / round-robin scheduler unit.
`default_nettype none
module tb_multicore_rr_fcfs_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mcrrs_pkg::*;

    localparam int NCORE = 4;
    localparam int QD    = 16;

    typedef struct {
        logic        op;
        logic [15:0] job;
        logic [15:0] cnt;
    } sched_req_t;

    typedef struct {
        kind_t       kind;
        logic [1:0]  core;
        logic [15:0] job;
        logic        idle;
        logic [31:0] ic;
        logic [31:0] ac;
        logic        last;
    } sched_ev_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [15:0] job_id;
    logic [15:0] instr_count;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  event_kind;
    logic [1:0]  core_index;
    logic [15:0] event_job;
    logic        tick_idle;
    logic [31:0] idle_ticks;
    logic [31:0] active_ticks;
    logic        last_event;

    multicore_rr_fcfs_scheduler_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .job_id(job_id), .instr_count(instr_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_kind(event_kind), .core_index(core_index), .event_job(event_job),
        .tick_idle(tick_idle), .idle_ticks(idle_ticks), .active_ticks(active_ticks),
        .last_event(last_event)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    sched_req_t  pending_q[$];
    sched_ev_t   events_due[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_preempt;
    int          n_full;
    int          n_finish;

    // scheduler mirror
    logic        m_mode;
    logic [15:0] m_delay;
    logic [15:0] m_quant;
    logic [2:0]  m_cores;
    logic [15:0] rq_job [QD];
    logic [15:0] rq_rem [QD];
    int          rq_head;
    int          rq_cnt;
    logic        cpu_busy  [NCORE];
    logic [15:0] cpu_job   [NCORE];
    logic [15:0] cpu_rem   [NCORE];
    logic [15:0] cpu_delay [NCORE];
    logic [15:0] cpu_quant [NCORE];
    logic [31:0] n_idle;
    logic [31:0] n_active;

    function automatic void post_event(kind_t k, int c, logic [15:0] j, logic idl,
                                       logic [31:0] ic, logic [31:0] ac);
        sched_ev_t e;
        e.kind = k;
        e.core = c[1:0];
        e.job  = j;
        e.idle = idl;
        e.ic   = ic;
        e.ac   = ac;
        e.last = 1'b0;
        events_due.insert(events_due.size(), e);
    endfunction

    function automatic void mark_last();
        events_due[events_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void rq_push(logic [15:0] j, logic [15:0] r);
        int slot;
        slot = (rq_head + rq_cnt) % QD;
        rq_job[slot] = j;
        rq_rem[slot] = r;
        rq_cnt++;
    endfunction

    function automatic void run_dispatch(int c);
        cpu_job[c]  = rq_job[rq_head];
        cpu_rem[c]  = rq_rem[rq_head];
        rq_head     = (rq_head + 1) % QD;
        rq_cnt--;
        cpu_busy[c] = 1'b1;
        post_event(EV_DISP, c, cpu_job[c], 1'b0, 0, 0);
    endfunction

    function automatic void predict_events(sched_req_t r);
        int          n;
        logic        any_busy;
        logic [15:0] hj;
        logic [15:0] hr;
        if (r.op == 1'b0)
        begin
            if (rq_cnt >= QD)
                post_event(EV_FULL, 0, r.job, 1'b0, 0, 0);
            else
            begin
                rq_push(r.job, r.cnt);
                post_event(EV_ENQ, 0, r.job, 1'b0, 0, 0);
            end
            mark_last();
            return;
        end
        n = m_cores;
        if (n < 1) n = 1;
        if (n > NCORE) n = NCORE;
        for (int c = 0; c < n; c++)
        begin
            if (m_mode == 1'b0)
            begin
                if (rq_cnt == 0) break;
                if (!cpu_busy[c]) run_dispatch(c);
            end
            else if (!cpu_busy[c])
            begin
                if (rq_cnt != 0) run_dispatch(c);
            end
            else if (cpu_quant[c] == 16'd0)
            begin
                hj = cpu_job[c];
                hr = cpu_rem[c];
                cpu_quant[c] = m_quant;
                post_event(EV_PRE, c, hj, 1'b0, 0, 0);
                if (rq_cnt != 0)
                begin
                    run_dispatch(c);
                    rq_push(hj, hr);
                end
                else
                    post_event(EV_DISP, c, hj, 1'b0, 0, 0);
            end
        end
        any_busy = 1'b0;
        for (int c = 0; c < n; c++)
            if (cpu_busy[c]) any_busy = 1'b1;
        if (any_busy) n_active++;
        else n_idle++;
        for (int c = 0; c < n; c++)
        begin
            if (!cpu_busy[c]) continue;
            if (cpu_delay[c] == 16'd0)
            begin
                cpu_delay[c] = m_delay;
                cpu_rem[c]   = cpu_rem[c] - 16'd1;
                if (cpu_rem[c] == 16'd0)
                begin
                    cpu_busy[c]  = 1'b0;
                    cpu_quant[c] = m_quant;
                    post_event(EV_FIN, c, cpu_job[c], 1'b0, 0, 0);
                end
                else if (cpu_quant[c] != 16'd0)
                    cpu_quant[c]--;
            end
            else
                cpu_delay[c]--;
        end
        post_event(EV_SUM, 0, 16'd0, !any_busy, n_idle, n_active);
        mark_last();
    endfunction

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_events('{op: operation, job: job_id, cnt: instr_count});
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    in_valid  <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    sched_req_t r;
                    r = pending_q.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= r.op;
                    job_id      <= r.job;
                    instr_count <= r.cnt;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus two long holds
    int rx_cyc;
    int rx_hold;
    int rx_mode;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cyc <= rx_cyc + 1;
            if (rx_cyc % 150 == 0)
                rx_mode <= $urandom_range(0, 2);
            if (rx_hold > 0)
            begin
                rx_hold   <= rx_hold - 1;
                out_ready <= 1'b0;
            end
            else if (rx_cyc == 1500 || rx_cyc == 20000)
            begin
                rx_hold   <= 500;
                out_ready <= 1'b0;
            end
            else if (rx_mode == 0)
                out_ready <= 1'b1;
            else if (rx_mode == 1)
                out_ready <= ($urandom_range(0, 9) < 7);
            else
                out_ready <= ($urandom_range(0, 9) < 3);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                $error("unexpected result transaction kind %0d job %0h", event_kind, event_job);
                errors++;
            end
            else
            begin
                sched_ev_t e;
                e = events_due.pop_front();
                n_checked++;
                if (e.kind == EV_PRE) n_preempt++;
                if (e.kind == EV_FULL) n_full++;
                if (e.kind == EV_FIN) n_finish++;
                if (event_kind !== e.kind)
                begin
                    $error("event_kind exp %0d got %0d", e.kind, event_kind);
                    errors++;
                end
                if (core_index !== e.core)
                begin
                    $error("core_index exp %0d got %0d", e.core, core_index);
                    errors++;
                end
                if (event_job !== e.job)
                begin
                    $error("event_job exp %0h got %0h", e.job, event_job);
                    errors++;
                end
                if (tick_idle !== e.idle)
                begin
                    $error("tick_idle exp %0d got %0d", e.idle, tick_idle);
                    errors++;
                end
                if (idle_ticks !== e.ic)
                begin
                    $error("idle_ticks exp %0d got %0d", e.ic, idle_ticks);
                    errors++;
                end
                if (active_ticks !== e.ac)
                begin
                    $error("active_ticks exp %0d got %0d", e.ac, active_ticks);
                    errors++;
                end
                if (last_event !== e.last)
                begin
                    $error("last_event exp %0d got %0d", e.last, last_event);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || events_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MODE:    m_mode  = val[0];
            REG_DELAY:   m_delay = val;
            REG_QUANTUM: m_quant = val;
            REG_ACTIVE:  m_cores = val[2:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup(logic md, logic [15:0] dl, logic [15:0] qt, logic [15:0] ac);
        wait_drained();
        write_reg(REG_MODE, {15'd0, md});
        write_reg(REG_DELAY, dl);
        write_reg(REG_QUANTUM, qt);
        write_reg(REG_ACTIVE, ac);
    endtask

    task automatic add_req(logic op, logic [15:0] j, logic [15:0] c);
        pending_q.insert(pending_q.size(), '{op: op, job: j, cnt: c});
    endtask

    task automatic add_random(int n, int maxcnt);
        int r;
        logic [15:0] c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0) c = 16'd0;
            else if (r == 1) c = 16'($urandom);
            else c = 16'($urandom_range(1, maxcnt));
            add_req($urandom_range(0, 99) < 45 ? 1'b0 : 1'b1, 16'($urandom), c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; operation = 1'b0; job_id = '0; instr_count = '0;
        out_ready = 1'b0;
        errors = 0; n_sent = 0; n_checked = 0; n_preempt = 0; n_full = 0; n_finish = 0;
        burst_left = 0; gap_left = 0; rx_cyc = 0; rx_hold = 0; rx_mode = 0;
        m_mode = 1'b0; m_delay = DELAY_RST; m_quant = QUANT_RST; m_cores = ACT_RST;
        rq_head = 0; rq_cnt = 0; n_idle = 0; n_active = 0;
        for (int c = 0; c < NCORE; c++)
        begin
            cpu_busy[c] = 1'b0; cpu_job[c] = '0; cpu_rem[c] = '0;
            cpu_delay[c] = DELAY_RST; cpu_quant[c] = QUANT_RST;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: an idle tick, field extremes, zero count, fill to overflow
        add_req(1'b1, 16'h0000, 16'h0001);
        add_req(1'b0, 16'h0000, 16'h0001);
        add_req(1'b0, 16'hFFFF, 16'hFFFF);
        add_req(1'b0, 16'h1234, 16'h0000);
        for (int i = 0; i < 14; i++)
            add_req(1'b0, 16'h0100 + i, 16'd2 + i);
        add_req(1'b1, 16'hFFFF, 16'hFFFF);
        add_req(1'b1, 16'h0000, 16'h0000);
        add_req(1'b1, 16'hAAAA, 16'h5555);
        setup(1'b1, 16'd0, 16'd0, 16'd4);
        for (int i = 0; i < 4; i++)
            add_req(1'b1, 16'h5555, 16'hAAAA);

        setup(1'b0, 16'd0, 16'd5, 16'd4);
        add_random(80, 6);
        setup(1'b1, 16'd0, 16'd1, 16'd4);
        add_random(80, 8);
        setup(1'b1, 16'd1, 16'd0, 16'd2);
        add_random(60, 4);
        setup(1'b1, 16'd0, 16'd65535, 16'd0);
        add_random(50, 5);
        setup(1'b0, 16'd2, 16'd2, 16'd3);
        add_random(40, 6);
        setup(1'b1, 16'd0, 16'd2, 16'd3);
        add_random(60, 8);
        setup(1'b1, 16'd0, 16'd3, 16'd1);
        add_random(50, 4);
        setup(1'b0, 16'd65535, 16'd1, 16'd7);
        add_random(40, 8);

        wait_drained();
        $display("summary: %0d transactions sent, %0d results checked", n_sent, n_checked);
        $display("summary: %0d preempts, %0d finishes, %0d queue-full", n_preempt, n_finish,
                 n_full);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
